// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Each macro reports through $error with the message given by the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define RTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Same-cycle implication.
`define RTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define RTC_ASSERT(lbl, clk, rstn, prop, msg)
`define RTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: rtl/rtc3_pkg.sv
// ----------------------------------------------------------------------------
// rtc3_pkg
// Types and constants for the three-wire RTC byte master.
// ----------------------------------------------------------------------------
package rtc3_pkg;

    localparam int PHASE_W = 6;
    localparam int TICK_W  = 8;

    // transfer commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0]         READ_FLAG         = 8'h01;
    localparam logic [PHASE_W-1:0] READ_FIRST_SAMPLE = 6'd16;
    localparam logic [PHASE_W-1:0] READ_LAST_PHASE   = 6'd30;
    localparam logic [PHASE_W-1:0] WRITE_LAST_PHASE  = 6'd32;
    localparam logic [TICK_W-1:0]  PHASE_TICKS_RST   = 8'd1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] command_byte;
        logic [7:0] write_data;
        logic       io_in;
    } rtc3_in_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } rtc3_out_t;

    // one computed result handed to the output stage
    typedef struct packed {
        logic      valid;
        rtc3_out_t data;
    } rtc3_res_t;

endpackage

// File: rtl/rtc3_seq.sv
// ----------------------------------------------------------------------------
// rtc3_seq
// Pin-level sequencer: holds transfer state and advances it by one tick per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtc3_seq
    import rtc3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       step_en,
    input  rtc3_in_t   item,
    output rtc3_res_t  res
);

    logic [TICK_W-1:0]  phase_ticks_reg;
    logic [PHASE_W-1:0] phase_index_reg, phase_index_next;
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic               transfer_active_reg, transfer_active_next;
    logic               is_read_reg, is_read_next;
    logic [15:0]        shift_out_reg, shift_out_next;
    logic [7:0]         shift_in_reg, shift_in_next;

    logic [TICK_W-1:0]  pt;
    logic [TICK_W-1:0]  tick_inc;
    logic [PHASE_W-1:0] last_phase;
    logic               done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_wr_en) begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_index_reg     <= '0;
            tick_count_reg      <= '0;
            transfer_active_reg <= 1'b0;
            is_read_reg         <= 1'b0;
            shift_out_reg       <= '0;
            shift_in_reg        <= '0;
        end else begin
            phase_index_reg     <= phase_index_next;
            tick_count_reg      <= tick_count_next;
            transfer_active_reg <= transfer_active_next;
            is_read_reg         <= is_read_next;
            shift_out_reg       <= shift_out_next;
            shift_in_reg        <= shift_in_next;
        end
    end

    assign pt         = (phase_ticks_reg == '0) ? PHASE_TICKS_RST : phase_ticks_reg;
    assign tick_inc   = tick_count_reg + TICK_W'(1);
    assign last_phase = is_read_reg ? READ_LAST_PHASE : WRITE_LAST_PHASE;

    // state update
    always_comb begin
        phase_index_next     = phase_index_reg;
        tick_count_next      = tick_count_reg;
        transfer_active_next = transfer_active_reg;
        is_read_next         = is_read_reg;
        shift_out_next       = shift_out_reg;
        shift_in_next        = shift_in_reg;
        done                 = 1'b0;
        if (step_en) begin
            if (!transfer_active_reg) begin
                // starts are only seen while idle
                if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
                    transfer_active_next = 1'b1;
                    is_read_next         = (item.cmd == CMD_READ);
                    phase_index_next     = '0;
                    tick_count_next      = '0;
                    if (item.cmd == CMD_READ) begin
                        shift_out_next = {8'h00, item.command_byte | READ_FLAG};
                    end else begin
                        shift_out_next = {item.write_data, item.command_byte};
                    end
                end
            end else begin
                tick_count_next = tick_inc;
                if (tick_inc >= pt) begin
                    tick_count_next = '0;
                    // sample at the end of each read clock-low phase
                    if (is_read_reg && phase_index_reg >= READ_FIRST_SAMPLE
                        && !phase_index_reg[0]) begin
                        shift_in_next = {item.io_in, shift_in_reg[7:1]};
                    end
                    if (phase_index_reg >= last_phase) begin
                        transfer_active_next = 1'b0;
                        phase_index_next     = '0;
                        done                 = 1'b1;
                    end else begin
                        phase_index_next = phase_index_reg + PHASE_W'(1);
                    end
                end
            end
        end
    end

    // pin levels after the tick
    always_comb begin
        res.valid             = step_en;
        res.data.chip_enable  = 1'b0;
        res.data.serial_clock = 1'b0;
        res.data.io_out       = 1'b0;
        res.data.io_drive     = 1'b0;
        res.data.busy_res     = transfer_active_next;
        res.data.done_res     = done;
        res.data.read_data    = shift_in_next;
        if (transfer_active_next) begin
            res.data.chip_enable = 1'b1;
            if (is_read_next && phase_index_next >= READ_FIRST_SAMPLE) begin
                res.data.serial_clock = phase_index_next[0];
            end else if (phase_index_next >= WRITE_LAST_PHASE) begin
                res.data.io_drive = 1'b1;
                res.data.io_out   = shift_out_next[15];
            end else begin
                res.data.serial_clock = phase_index_next[0];
                res.data.io_drive     = 1'b1;
                res.data.io_out       = shift_out_next[phase_index_next[4:1]];
            end
        end
    end

    `RTC_ASSERT_IMP(a_idle_clear, aclk, aresetn, !transfer_active_reg, phase_index_reg == '0 && tick_count_reg == '0, "idle with stale phase or tick count")
    `RTC_ASSERT_IMP(a_phase_bound, aclk, aresetn, transfer_active_reg, phase_index_reg <= last_phase, "phase index past last phase")
    `RTC_ASSERT_NXT(a_done_idle, aclk, aresetn, step_en && res.data.done_res, !transfer_active_reg && !$past(is_read_reg) == !is_read_reg, "transfer still active after done")
    `RTC_ASSERT_IMP(a_idle_pins, aclk, aresetn, step_en && !res.data.busy_res, !res.data.chip_enable && !res.data.serial_clock && !res.data.io_drive && !res.data.io_out, "pins not idle outside a transfer")

endmodule

// File: rtl/rtc3_out_buf.sv
// ----------------------------------------------------------------------------
// rtc3_out_buf
// Result register with a skid stage so input is taken while a result waits.
// ----------------------------------------------------------------------------
module rtc3_out_buf
    import rtc3_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  rtc3_res_t res,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output rtc3_out_t m_data
);

    logic      main_valid_reg;
    rtc3_out_t main_data_reg;
    logic      skid_valid_reg;
    rtc3_out_t skid_data_reg;
    logic      pop;

    assign in_ready = !skid_valid_reg;
    assign pop      = main_valid_reg && m_ready;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (res.valid) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (res.valid) begin
            if (!main_valid_reg || pop) begin
                main_data_reg <= res.data;
            end else begin
                skid_data_reg <= res.data;
            end
        end
    end

endmodule

// File: rtl/three_wire_rtc_byte_master_core.sv
// Each result is registered in the output buffer before the m_ side shows it.
// Throughput: one item per cycle while s_ready is high; sequencer state update
// is a single short combinational step between state and result registers.
// A two-entry output buffer keeps s_ready high while one result is stalled.
// Reset (aresetn low, synchronous) idles the bus, clears state and read data,
// sets phase_ticks to 1 and empties the output buffer.
// ----------------------------------------------------------------------------
// three_wire_rtc_byte_master_core
// Three-wire RTC bus master, advanced one tick per item.
// ----------------------------------------------------------------------------
module three_wire_rtc_byte_master_core
    import rtc3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  rtc3_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rtc3_out_t  m_data
);

    logic      step_en;
    rtc3_res_t res;

    assign step_en = s_valid && s_ready;

    rtc3_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .item        (s_data),
        .res         (res)
    );

    rtc3_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// File: tb/sv/three_wire_rtc_byte_master_core_tb.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_byte_master_core_tb
// Self-checking bench for the three-wire RTC byte master. Every accepted item
// is one bus tick; a local pin-level model predicts the pins, busy, done and
// read byte for each tick, and each result is checked in order. Runs directed
// start cases, then random write/read transfers over several phase lengths
// and three handshake idling patterns.
// ----------------------------------------------------------------------------
module three_wire_rtc_byte_master_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc3_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         LIMIT      = 300000;
    localparam int         DRAIN_GAP  = 8;
    localparam int         LONG_PHASE_ITEMS = 300;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    rtc3_in_t  s_data      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    rtc3_out_t m_data;

    // bus model state
    logic [7:0]         phase_ticks_m = PHASE_TICKS_RST;
    logic [PHASE_W-1:0] bus_phase     = '0;
    logic [TICK_W-1:0]  phase_tick_cnt = '0;
    logic               xfer_busy     = 1'b0;
    logic               xfer_is_read  = 1'b0;
    logic [15:0]        tx_shift      = '0;
    logic [7:0]         rx_byte       = '0;

    rtc3_out_t expected_pins[$];
    rtc3_out_t want_pins;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int errors        = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int xfers_done    = 0;
    int cycles        = 0;

    three_wire_rtc_byte_master_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("three_wire_rtc_byte_master_core test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Advance the bus model by one tick and return the pins after it.
    function automatic rtc3_out_t next_pin_state(input rtc3_in_t it);
        rtc3_out_t          pins;
        logic [7:0]         ticks_lim;
        logic [PHASE_W-1:0] last_phase;
        pins = '0;
        if (!xfer_busy) begin
            if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
                xfer_busy      = 1'b1;
                xfer_is_read   = (it.cmd == CMD_READ);
                bus_phase      = '0;
                phase_tick_cnt = '0;
                if (xfer_is_read)
                    tx_shift = {8'h00, it.command_byte | READ_FLAG};
                else
                    tx_shift = {it.write_data, it.command_byte};
            end
        end else begin
            ticks_lim      = (phase_ticks_m == 8'd0) ? 8'd1 : phase_ticks_m;
            phase_tick_cnt = phase_tick_cnt + 1'b1;
            if (phase_tick_cnt >= ticks_lim) begin
                phase_tick_cnt = '0;
                last_phase = xfer_is_read ? READ_LAST_PHASE : WRITE_LAST_PHASE;
                // sample at the end of each read clock-low phase
                if (xfer_is_read && bus_phase >= READ_FIRST_SAMPLE && !bus_phase[0])
                    rx_byte = {it.io_in, rx_byte[7:1]};
                if (bus_phase >= last_phase) begin
                    xfer_busy     = 1'b0;
                    bus_phase     = '0;
                    pins.done_res = 1'b1;
                end else begin
                    bus_phase = bus_phase + 1'b1;
                end
            end
        end
        if (xfer_busy) begin
            pins.chip_enable = 1'b1;
            if (xfer_is_read && bus_phase >= READ_FIRST_SAMPLE) begin
                pins.serial_clock = bus_phase[0];
            end else if (bus_phase >= WRITE_LAST_PHASE) begin
                pins.io_drive = 1'b1;
                pins.io_out   = tx_shift[15];
            end else begin
                pins.serial_clock = bus_phase[0];
                pins.io_drive     = 1'b1;
                pins.io_out       = tx_shift[bus_phase[4:1]];
            end
        end
        pins.busy_res  = xfer_busy;
        pins.read_data = rx_byte;
        return pins;
    endfunction

    // Mostly well-formed: starts when idle, plain ticks when busy.
    function automatic rtc3_in_t pick_bus_item();
        rtc3_in_t it;
        int       roll;
        it.command_byte = 8'($urandom_range(255));
        it.write_data   = 8'($urandom_range(255));
        it.io_in        = 1'($urandom_range(1));
        roll            = int'($urandom_range(99));
        if (!xfer_busy)
            it.cmd = (roll < 85) ? (roll[0] ? CMD_WRITE : CMD_READ)
                                 : (roll[0] ? CMD_UNUSED : CMD_TICK);
        else
            it.cmd = (roll < 8)  ? (roll[0] ? CMD_WRITE : CMD_READ)
                   : (roll < 15) ? CMD_UNUSED : CMD_TICK;
        return it;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pins.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, m_data);
            end else begin
                want_pins = expected_pins.pop_front();
                results_seen++;
                if (want_pins.done_res)
                    xfers_done++;
                check_field("chip_enable", want_pins.chip_enable, m_data.chip_enable);
                check_field("serial_clock", want_pins.serial_clock, m_data.serial_clock);
                check_field("io_out", want_pins.io_out, m_data.io_out);
                check_field("io_drive", want_pins.io_drive, m_data.io_drive);
                check_field("busy_res", want_pins.busy_res, m_data.busy_res);
                check_field("done_res", want_pins.done_res, m_data.done_res);
                check_field("read_data", want_pins.read_data, m_data.read_data);
            end
        end
    end

    // Called right after a rising edge; returns at the edge that takes the item.
    task automatic send_item(input rtc3_in_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_pins.push_back(next_pin_state(it));
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic set_phase_ticks(input logic [7:0] ticks);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        phase_ticks_m  = ticks;
    endtask

    task automatic finish_transfer();
        while (xfer_busy) send_item(pick_bus_item());
    endtask

    // Field extremes, unused code, and starts that arrive while busy.
    task automatic test_directed_starts();
        send_item('{cmd: CMD_TICK, command_byte: 8'h00, write_data: 8'h00, io_in: 1'b0});
        send_item('{cmd: CMD_UNUSED, command_byte: 8'hFF, write_data: 8'hFF, io_in: 1'b1});
        send_item('{cmd: CMD_WRITE, command_byte: 8'h00, write_data: 8'hFF, io_in: 1'b1});
        send_item('{cmd: CMD_READ, command_byte: 8'hFF, write_data: 8'h00, io_in: 1'b1});
        send_item('{cmd: CMD_WRITE, command_byte: 8'h5A, write_data: 8'hA5, io_in: 1'b0});
        finish_transfer();
        // read with command bit 0 clear: the flag must force it
        send_item('{cmd: CMD_READ, command_byte: 8'h00, write_data: 8'hFF, io_in: 1'b0});
        finish_transfer();
    endtask

    task automatic test_random_transfers(input int n_items);
        repeat (n_items) send_item(pick_bus_item());
        finish_transfer();
    endtask

    task automatic test_phase_ticks(input logic [7:0] ticks, input int n_items);
        set_phase_ticks(ticks);
        test_random_transfers(n_items);
    endtask

    // Longest phase: run past the first 255-tick phase boundary, then shorten
    // the phases to 1 tick so the transfer finishes.
    task automatic test_max_phase_ticks();
        set_phase_ticks(8'd255);
        send_item('{cmd: CMD_WRITE, command_byte: 8'($urandom_range(255)),
                    write_data: 8'($urandom_range(255)), io_in: 1'b1});
        repeat (LONG_PHASE_ITEMS) send_item(pick_bus_item());
        set_phase_ticks(8'd1);
        finish_transfer();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 38;
        sink_idle_pct = 61;
        test_directed_starts();
        test_random_transfers(180);
        test_phase_ticks(8'd2, 130);

        src_idle_pct  = 61;
        sink_idle_pct = 38;
        test_phase_ticks(8'd0, 130);
        test_phase_ticks(8'd3, 150);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_max_phase_ticks();
        test_phase_ticks(8'd1, 150);

        drain_results();
        $display("Sent %0d ticks, checked %0d results, %0d transfers completed",
                 items_sent, results_seen, xfers_done);
        $display("Phase lengths 0, 1, 2, 3 and 255 under three idling patterns");
        if (errors == 0)
            $display("three_wire_rtc_byte_master_core test passed");
        else
            $display("three_wire_rtc_byte_master_core test failed");
        $finish;
    end

endmodule

// File: three_wire_rtc_byte_master_core.f
+incdir+rtl
rtl/rtc3_pkg.sv
rtl/rtc3_seq.sv
rtl/rtc3_out_buf.sv
rtl/three_wire_rtc_byte_master_core.sv
tb/sv/three_wire_rtc_byte_master_core_tb.sv
